### rtl/bale_pkg.sv
package bale_pkg;

    localparam int BALE_DEPTH      = 64;
    localparam int BALE_DATA_WIDTH = 32;
    localparam int FUNC_W          = 3;
    localparam int POS_W           = 7;
    localparam int CAP_W           = 7;
    localparam int CAP_RESET       = 64;

    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SORT    = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE,
        CELL_TAG,
        CELL_SORT,
        CELL_REV
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     parity;
    } t_cell_ctl;

endpackage

### rtl/bale_cell.sv
module bale_cell
    import bale_pkg::*;
#(
    parameter int DEPTH      = BALE_DEPTH,
    parameter int DATA_WIDTH = BALE_DATA_WIDTH,
    parameter int INDEX      = 0,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_k,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [IDX_W-1:0]      i_left_tag,
    input  logic                  i_left_swap,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic [IDX_W-1:0]      i_right_tag,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [IDX_W-1:0]      o_tag,
    output logic                  o_swap,
    output logic [DATA_WIDTH-1:0] o_pick
);

    localparam logic PAR = ((INDEX % 2) == 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [IDX_W-1:0]      r_tag;
    logic [IDX_W-1:0]      n_tag;
    logic                  is_k;
    logic                  above_k;
    logic                  lower;
    logic                  upper;
    logic                  cmp;

    assign is_k    = (i_k == IDX_W'(INDEX));
    assign above_k = (i_k < IDX_W'(INDEX));
    assign lower   = (i_ctl.parity == PAR) && (CNT_W'(INDEX + 1) < i_count);
    assign upper   = (INDEX > 0) && (i_ctl.parity != PAR);

    always_comb begin
        case (i_ctl.op)
            CELL_SORT: cmp = ($signed(r_data) > $signed(i_right_data));
            CELL_REV:  cmp = (r_tag < i_right_tag);
            default:   cmp = 1'b0;
        endcase
    end

    assign o_swap = lower && cmp;

    always_comb begin
        n_data = r_data;
        n_tag  = r_tag;
        unique case (i_ctl.op)
            CELL_WRITE: begin
                if (is_k) n_data = i_value;
            end
            CELL_INSERT: begin
                if (is_k) n_data = i_value;
                else if (above_k) n_data = i_left_data;
            end
            CELL_DELETE: begin
                if (is_k || above_k) n_data = i_right_data;
            end
            CELL_TAG: begin
                n_tag = IDX_W'(INDEX);
            end
            CELL_SORT, CELL_REV: begin
                if (o_swap) begin
                    n_data = i_right_data;
                    n_tag  = i_right_tag;
                end else if (upper && i_left_swap) begin
                    n_data = i_left_data;
                    n_tag  = i_left_tag;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tag  <= n_tag;
    end

    assign o_data = r_data;
    assign o_tag  = r_tag;
    assign o_pick = is_k ? r_data : '0;

endmodule

### rtl/bounded_array_list_engine.sv
// bounded list of signed values held in a row of cells, one entry per cell
// input channel: i_in_valid / o_in_stall with i_func, i_position, i_value;
//   a transaction is taken on a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall with o_ok, o_removed_value,
//   o_count, o_empty_res, o_full_res; one result per input transaction
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_capacity, always ready;
//   write it only while no transaction is in flight
// append, insert, delete and refused or unknown operations finish in the
//   cycle of acceptance; the result is registered and the next transaction
//   may follow immediately (one per cycle while the input is not stalled)
// reverse and sort run odd-even transposition over the cell chain: one pass
//   per cycle, count passes after a tag step, for count > 1; the input is
//   stalled during the passes
// a stalled result sits in the output register while one more result can be
//   held behind it; the input stalls once both are occupied
// reset (synchronous, active low) empties the list, sets capacity to 64 and
//   drops pending results; entry contents are not cleared
module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int DEPTH      = BALE_DEPTH,
    parameter int DATA_WIDTH = BALE_DATA_WIDTH,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [FUNC_W-1:0]            i_func,
    input  logic [POS_W-1:0]             i_position,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ok,
    output logic signed [DATA_WIDTH-1:0] o_removed_value,
    output logic [CNT_W-1:0]             o_count,
    output logic                         o_empty_res,
    output logic                         o_full_res,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CAP_W-1:0]             i_cfg_capacity
);

    localparam int WW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CAP_W-1:0]      r_cap;
    logic [CNT_W-1:0]      r_phase;
    logic [CNT_W-1:0]      n_phase;
    logic                  r_is_sort;

    logic                  r_out_v;
    logic                  r_out_ok;
    logic [DATA_WIDTH-1:0] r_out_rem;
    logic [CNT_W-1:0]      r_out_cnt;
    logic                  r_out_empty;
    logic                  r_out_full;
    logic                  r_pend_v;
    logic                  r_pend_ok;
    logic [DATA_WIDTH-1:0] r_pend_rem;
    logic [CNT_W-1:0]      r_pend_cnt;
    logic                  r_pend_empty;
    logic                  r_pend_full;

    logic                  in_acc;
    logic                  out_take;
    logic [WW-1:0]         pos_w;
    logic [WW-1:0]         cnt_w;
    logic [WW-1:0]         cap_w;
    logic [WW-1:0]         res_cnt_w;
    logic                  full_now;
    logic                  append_ok;
    logic                  insert_ok;
    logic                  delete_ok;
    logic                  res_v;
    logic                  res_ok;
    logic [DATA_WIDTH-1:0] res_rem;
    logic                  res_full;
    logic [DATA_WIDTH-1:0] pick_or;
    t_cell_ctl             ctl;
    logic [IDX_W-1:0]      k;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [IDX_W-1:0]      w_tag  [DEPTH];
    logic                  w_swap [DEPTH];
    logic [DATA_WIDTH-1:0] w_pick [DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE) || r_pend_v;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_v && !i_out_stall;

    assign pos_w     = WW'(i_position);
    assign cnt_w     = WW'(r_count);
    assign cap_w     = WW'(r_cap);
    assign full_now  = (cnt_w >= cap_w) || (r_count == CNT_W'(DEPTH));
    assign append_ok = !full_now;
    assign insert_ok = !full_now && (i_position != '0) && (pos_w <= cnt_w + WW'(1));
    assign delete_ok = (r_count != '0) && (i_position != '0) && (pos_w <= cnt_w);

    always_comb begin
        pick_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pick_or = pick_or | w_pick[i];
        end
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_phase        = r_phase;
        ctl.op         = CELL_HOLD;
        ctl.parity     = r_phase[0];
        k              = IDX_W'(pos_w - WW'(1));
        res_v          = 1'b0;
        res_ok         = 1'b0;
        res_rem        = '0;
        if (r_state == ST_RUN) begin
            ctl.op = r_is_sort ? CELL_SORT : CELL_REV;
            n_phase = r_phase + CNT_W'(1);
            if (r_phase == r_count - CNT_W'(1)) begin
                n_state = ST_IDLE;
                res_v   = 1'b1;
                res_ok  = 1'b1;
            end
        end else if (in_acc) begin
            res_v = 1'b1;
            case (i_func)
                FUNC_APPEND: begin
                    k = r_count[IDX_W-1:0];
                    if (append_ok) begin
                        ctl.op  = CELL_WRITE;
                        n_count = r_count + CNT_W'(1);
                        res_ok  = 1'b1;
                    end
                end
                FUNC_INSERT: begin
                    if (insert_ok) begin
                        ctl.op  = CELL_INSERT;
                        n_count = r_count + CNT_W'(1);
                        res_ok  = 1'b1;
                    end
                end
                FUNC_DELETE: begin
                    if (delete_ok) begin
                        ctl.op  = CELL_DELETE;
                        n_count = r_count - CNT_W'(1);
                        res_ok  = 1'b1;
                        res_rem = pick_or;
                    end
                end
                FUNC_REVERSE, FUNC_SORT: begin
                    if (r_count > CNT_W'(1)) begin
                        ctl.op  = CELL_TAG;
                        n_state = ST_RUN;
                        n_phase = '0;
                        res_v   = 1'b0;
                    end else begin
                        res_ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign res_cnt_w = WW'(n_count);
    assign res_full  = (res_cnt_w >= cap_w) || (n_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_cap    <= CAP_W'(CAP_RESET);
            r_phase  <= '0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_phase <= n_phase;
            if (i_cfg_valid) r_cap <= i_cfg_capacity;
            if (res_v) begin
                if (!r_out_v || out_take) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_pend_v <= 1'b1;
                end
            end else if (out_take) begin
                r_out_v  <= r_pend_v;
                r_pend_v <= 1'b0;
            end
        end
        if (r_state == ST_IDLE && in_acc) r_is_sort <= (i_func == FUNC_SORT);
        if (res_v) begin
            if (!r_out_v || out_take) begin
                r_out_ok    <= res_ok;
                r_out_rem   <= res_rem;
                r_out_cnt   <= n_count;
                r_out_empty <= (n_count == '0);
                r_out_full  <= res_full;
            end else begin
                r_pend_ok    <= res_ok;
                r_pend_rem   <= res_rem;
                r_pend_cnt   <= n_count;
                r_pend_empty <= (n_count == '0);
                r_pend_full  <= res_full;
            end
        end else if (out_take) begin
            r_out_ok    <= r_pend_ok;
            r_out_rem   <= r_pend_rem;
            r_out_cnt   <= r_pend_cnt;
            r_out_empty <= r_pend_empty;
            r_out_full  <= r_pend_full;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_ok            = r_out_ok;
    assign o_removed_value = r_out_rem;
    assign o_count         = r_out_cnt;
    assign o_empty_res     = r_out_empty;
    assign o_full_res      = r_out_full;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [IDX_W-1:0]      left_tag;
        logic                  left_swap;
        logic [DATA_WIDTH-1:0] right_data;
        logic [IDX_W-1:0]      right_tag;

        if (g == 0) begin : g_first
            assign left_data = '0;
            assign left_tag  = '0;
            assign left_swap = 1'b0;
        end else begin : g_mid
            assign left_data = w_data[g-1];
            assign left_tag  = w_tag[g-1];
            assign left_swap = w_swap[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = w_data[g];
            assign right_tag  = w_tag[g];
        end else begin : g_inner
            assign right_data = w_data[g+1];
            assign right_tag  = w_tag[g+1];
        end

        bale_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_k          (k),
            .i_count      (r_count),
            .i_value      (i_value),
            .i_left_data  (left_data),
            .i_left_tag   (left_tag),
            .i_left_swap  (left_swap),
            .i_right_data (right_data),
            .i_right_tag  (right_tag),
            .o_data       (w_data[g]),
            .o_tag        (w_tag[g]),
            .o_swap       (w_swap[g]),
            .o_pick       (w_pick[g])
        );
    end

endmodule

### dv/bounded_array_list_engine_test.sv
`timescale 1ns / 1ps

module bounded_array_list_engine_test;
    import bale_pkg::*;

    localparam int DW           = BALE_DATA_WIDTH;
    localparam int CNT_W        = $clog2(BALE_DEPTH + 1);
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * BALE_DEPTH + 8;
    localparam int NUM_PHASES   = 9;

    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                 ok;
        logic signed [DW-1:0] removed;
        logic [CNT_W-1:0]     count;
        logic                 empty;
        logic                 full;
    } t_list_res;

    typedef struct {
        logic                 cfg;
        logic [CAP_W-1:0]     cap;
        logic [FUNC_W-1:0]    func;
        logic [POS_W-1:0]     pos;
        logic signed [DW-1:0] value;
        logic                 known;
        t_list_res            res;
    } t_list_row;

    localparam t_list_res NO_RES = '0;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic [FUNC_W-1:0]    i_func         = '0;
    logic [POS_W-1:0]     i_position     = '0;
    logic signed [DW-1:0] i_value        = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CAP_W-1:0]     i_cfg_capacity = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_ok;
    logic signed [DW-1:0] o_removed_value;
    logic [CNT_W-1:0]     o_count;
    logic                 o_empty_res;
    logic                 o_full_res;
    logic                 o_cfg_ready;

    logic                 item_known = 1'b0;
    t_list_res            item_res   = '0;

    logic signed [DW-1:0] list_mem [BALE_DEPTH];
    int                   list_len = 0;
    logic [CAP_W-1:0]     cap_reg  = CAP_W'(CAP_RESET);

    t_list_res            pending_status_q [$];
    t_list_row            dir_q [$];
    int                   err_cnt      = 0;
    int                   quiet_cycles = 0;
    int                   send_pct     = 6;
    int                   recv_pct     = 76;

    bounded_array_list_engine i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_removed_value (o_removed_value),
        .o_count         (o_count),
        .o_empty_res     (o_empty_res),
        .o_full_res      (o_full_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_capacity  (i_cfg_capacity)
    );

    always #5 i_clk = ~i_clk;

    task automatic apply_list_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                                 input logic signed [DW-1:0] v, output t_list_res r);
        int                   eff;
        int                   pi;
        int                   k;
        int                   m;
        logic signed [DW-1:0] t;
        eff = (cap_reg > BALE_DEPTH) ? BALE_DEPTH : int'(cap_reg);
        pi  = int'(p);
        r   = '0;
        case (f)
            FUNC_APPEND: begin
                if (list_len < eff) begin
                    list_mem[list_len] = v;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FUNC_INSERT: begin
                if (list_len < eff && pi >= 1 && pi <= list_len + 1) begin
                    for (k = list_len; k >= pi; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pi-1] = v;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FUNC_DELETE: begin
                if (list_len > 0 && pi >= 1 && pi <= list_len) begin
                    r.removed = list_mem[pi-1];
                    for (k = pi; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            FUNC_REVERSE: begin
                for (k = 0; k < list_len / 2; k++) begin
                    t = list_mem[k];
                    list_mem[k] = list_mem[list_len-1-k];
                    list_mem[list_len-1-k] = t;
                end
                r.ok = 1'b1;
            end
            FUNC_SORT: begin
                for (k = 1; k < list_len; k++) begin
                    for (m = 0; m + k < list_len; m++) begin
                        if (list_mem[m] > list_mem[m+1]) begin
                            t = list_mem[m];
                            list_mem[m] = list_mem[m+1];
                            list_mem[m+1] = t;
                        end
                    end
                end
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(list_len);
        r.empty = (list_len == 0);
        r.full  = (list_len >= eff);
    endtask

    // expected status of an operation that removes nothing
    function automatic t_list_res known_status(input logic ok, input int cnt, input logic full);
        t_list_res r;
        r.ok      = ok;
        r.removed = '0;
        r.count   = CNT_W'(cnt);
        r.empty   = (cnt == 0);
        r.full    = full;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_value();
        case ($urandom_range(7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // monitor: predict on each accepted transaction, check each delivered result
    always @(posedge i_clk) begin : mon
        t_list_res want;
        t_list_res got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                cap_reg = i_cfg_capacity;
            if (i_in_valid && !o_in_stall) begin
                apply_list_op(i_func, i_position, i_value, want);
                if (item_known)
                    want = item_res;
                pending_status_q.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_ok, o_removed_value, o_count, o_empty_res, o_full_res};
                if (pending_status_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 20)
                        $display("%0t: unexpected result ok=%0b removed=%0d count=%0d empty=%0b full=%0b",
                                 $time, got.ok, got.removed, got.count, got.empty, got.full);
                end else begin
                    want = pending_status_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (err_cnt <= 20)
                            $display({"%0t: mismatch expected ok=%0b removed=%0d count=%0d ",
                                      "empty=%0b full=%0b actual ok=%0b removed=%0d count=%0d ",
                                      "empty=%0b full=%0b"},
                                     $time, want.ok, want.removed, want.count, want.empty,
                                     want.full, got.ok, got.removed, got.count, got.empty,
                                     got.full);
                    end
                end
            end
        end
    end

    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_pct);

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[bounded_array_list_engine] ERROR");
            $finish;
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic signed [DW-1:0] v, input logic known,
                           input t_list_res res);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_position <= p;
        i_value    <= v;
        item_known <= known;
        item_res   <= res;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status_q.size() != 0)
            @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= c;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_op(input bit grow);
        int                   r;
        int                   top;
        logic [FUNC_W-1:0]    f;
        logic [POS_W-1:0]     p;
        r   = $urandom_range(99);
        top = (list_len > 0) ? list_len : 1;
        p   = POS_W'($urandom_range(127));
        if (r < 3)
            f = FUNC_W'($urandom_range(FUNC_RSVD7, FUNC_RSVD5));
        else if (r < (grow ? 75 : 20))
            f = $urandom_range(1) ? FUNC_APPEND : FUNC_INSERT;
        else if (r < (grow ? 88 : 85))
            f = FUNC_DELETE;
        else if (r < (grow ? 94 : 93))
            f = FUNC_REVERSE;
        else
            f = FUNC_SORT;
        if (f == FUNC_INSERT && $urandom_range(4) != 0)
            p = POS_W'($urandom_range(list_len + 1, 1));
        else if (f == FUNC_DELETE && $urandom_range(4) != 0)
            p = POS_W'($urandom_range(top, 1));
        send_op(f, p, rand_value(), 1'b0, NO_RES);
    endtask

    initial begin : stim
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        int               phase_len [NUM_PHASES];
        int               ph;
        int               n;
        phase_cap = '{7'd64, 7'd3, 7'd127, 7'd1, 7'd64, 7'd0, 7'd40, 7'd127, 7'd2};
        phase_len = '{300, 200, 300, 150, 300, 60, 250, 300, 150};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, refused positions, unused codes, extremes, capacity below count
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd1, 0, 1'b1, known_status(0, 0, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_REVERSE, 7'd0, 0, 1'b1, known_status(1, 0, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_SORT, 7'd0, 0, 1'b1, known_status(1, 0, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd0, 5, 1'b1, known_status(0, 0, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd2, 5, 1'b1, known_status(0, 0, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_APPEND, 7'd0, VAL_MAX, 1'b1, known_status(1, 1, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd1, VAL_MIN, 1'b1, known_status(1, 2, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd3, -1, 1'b1, known_status(1, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd5, 9, 1'b1, known_status(0, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd4, 0, 1'b1, known_status(0, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd0, 0, 1'b1, known_status(0, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_RSVD5, 7'd127, -1, 1'b1, known_status(0, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_RSVD6, 7'd1, VAL_MIN, 1'b1, known_status(0, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_RSVD7, 7'd127, VAL_MAX, 1'b1, known_status(0, 3, 0)});
        dir_q.push_back('{1'b0, '0, FUNC_REVERSE, 7'd0, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_SORT, 7'd0, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd3, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd1, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b1, 7'd2, FUNC_APPEND, '0, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_APPEND, 7'd0, 1, 1'b1, known_status(0, 3, 1)});
        dir_q.push_back('{1'b0, '0, FUNC_INSERT, 7'd1, 1, 1'b1, known_status(0, 3, 1)});
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd2, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd1, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b1, 7'd0, FUNC_APPEND, '0, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_APPEND, 7'd0, 7, 1'b1, known_status(0, 1, 1)});
        dir_q.push_back('{1'b0, '0, FUNC_DELETE, 7'd1, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_SORT, 7'd0, 0, 1'b1, known_status(1, 0, 1)});
        dir_q.push_back('{1'b1, 7'd127, FUNC_APPEND, '0, 0, 1'b0, NO_RES});
        dir_q.push_back('{1'b0, '0, FUNC_APPEND, 7'd0, VAL_MAX, 1'b1, known_status(1, 1, 0)});

        foreach (dir_q[i]) begin
            if (dir_q[i].cfg)
                write_capacity(dir_q[i].cap);
            else
                send_op(dir_q[i].func, dir_q[i].pos, dir_q[i].value, dir_q[i].known,
                        dir_q[i].res);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity(phase_cap[ph]);
            send_pct = (ph < 3) ? 6 : (ph < 6) ? 76 : 0;
            recv_pct = (ph < 3) ? 76 : (ph < 6) ? 6 : 0;
            for (n = 0; n < phase_len[ph]; n++)
                send_random_op(n < (phase_len[ph] * 6) / 10);
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_status_q.size() == 0)
            $display("[bounded_array_list_engine] OK");
        else
            $display("[bounded_array_list_engine] ERROR");
        $finish;
    end

endmodule
